// ===== rtl/bdau_pkg.sv =====
// Shared constants and types for the binary to decimal ASCII unit.
// No dependencies; every other file imports this package.
package bdau_pkg;

  localparam int unsigned BIN_W              = 64;
  localparam int unsigned STORE_DEPTH        = 20;
  localparam int unsigned DIGIT_W            = 4;
  localparam int unsigned CHAR_W             = 6;
  localparam int unsigned STEP_W             = $clog2(BIN_W);
  localparam int unsigned PTR_W              = $clog2(STORE_DEPTH);
  localparam int unsigned DEFAULT_MAX_DIGITS = 20;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] ADJ_ADD    = DIGIT_W'(3);

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [STORE_DEPTH-1:0][DIGIT_W-1:0] bcd_t;

  // Sequencer commands to the shift-add-3 unit
  typedef struct packed {
    logic load;
    logic step;
  } dab_ctrl_t;

  // Status back from the shift-add-3 unit
  typedef struct packed {
    logic last_step;
  } dab_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_EMIT
  } bdau_state_e;

endpackage

// ===== rtl/bdau_if.sv =====
// Valid/ready channel interfaces for the binary to decimal ASCII unit.
// Depends on bdau_pkg for field widths.
interface bdau_in_if import bdau_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bdau_out_if import bdau_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ===== rtl/binary_to_decimal_ascii_unit.sv =====
// Binary to decimal ASCII unit: one 64-bit value in, its decimal digits out
// as ASCII, most significant first, last digit marked; zero gives no output.
// Steps: a load, the shift-add-3 conversion, a scan down past leading zeros, then
// one character per cycle while out is ready. A new value is accepted only in idle,
// once the previous value's last digit is loaded for output or the scan found it zero.
// Reset: asynchronous, clears the sequencer and output valid; digits are not cleared.
module binary_to_decimal_ascii_unit import bdau_pkg::*; #(
  parameter int unsigned MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bdau_in_if.sink    in_i,
  bdau_out_if.source out_o
);

  bdau_state_e       state_q, state_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic              out_valid_q, out_valid_d;
  digit_t            digit_q, digit_d;
  logic              last_q, last_d;
  dab_ctrl_t         dab_ctrl;
  dab_stat_t         dab_stat;
  bcd_t              digits;
  digit_t            sel_digit;
  logic              upper_nz;

  bdau_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (dab_ctrl),
    .value_i  (in_i.value),
    .stat_o   (dab_stat),
    .digits_o (digits)
  );

  // Any nonzero digit at or above MAX_DIGITS forces a full-width run
  always_comb begin
    upper_nz = 1'b0;
    for (int k = 0; k < STORE_DEPTH; k++) begin
      if (k >= MAX_DIGITS) begin
        upper_nz = upper_nz | (digits[k] != '0);
      end
    end
  end

  assign sel_digit = digits[ptr_q];

  // Sequencer: load, convert, skip leading zeros, emit
  always_comb begin
    state_d       = state_q;
    ptr_d         = ptr_q;
    out_valid_d   = out_valid_q & ~out_o.ready;
    digit_d       = digit_q;
    last_d        = last_q;
    dab_ctrl.load = 1'b0;
    dab_ctrl.step = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          dab_ctrl.load = 1'b1;
          state_d       = ST_CONV;
        end
      end
      ST_CONV: begin
        dab_ctrl.step = 1'b1;
        if (dab_stat.last_step) begin
          ptr_d   = PTR_W'(MAX_DIGITS - 1);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (upper_nz || sel_digit != '0) begin
          state_d = ST_EMIT;
        end else if (ptr_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q - PTR_W'(1);
        end
      end
      ST_EMIT: begin
        // Load the output register once it is free or being drained
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          digit_d     = sel_digit;
          last_d      = (ptr_q == '0);
          if (ptr_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d = ptr_q - PTR_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload holds until the transfer completes
  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    last_q  <= last_d;
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.digit_char = ASCII_ZERO + CHAR_W'(digit_q);
  assign out_o.last_digit = last_q;

  // An accepted value always starts a conversion
  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == ST_CONV)
    else $error("accepted value did not start conversion");

  // The digit pointer stays below MAX_DIGITS while emitting
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> ptr_q < PTR_W'(MAX_DIGITS))
    else $error("digit pointer beyond capacity");

  // A held digit is always a decimal digit
  a_digit_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> digit_q <= DIGIT_W'(9))
    else $error("output digit is not decimal");

  // Emitting the last digit returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT && ptr_q == '0 && (!out_valid_q || out_o.ready)
      |=> state_q == ST_IDLE && out_valid_q && last_q)
    else $error("last digit did not end the run");

endmodule

// ===== rtl/bdau_dabble.sv =====
// Shift-add-3 unit: turns the 64-bit binary value into 20 BCD digits,
// one bit per step. Depends on bdau_pkg.
module bdau_dabble import bdau_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dab_ctrl_t        ctrl_i,
  input  logic [BIN_W-1:0] value_i,
  output dab_stat_t        stat_o,
  output bcd_t             digits_o
);

  logic [BIN_W-1:0]  bin_q, bin_d;
  bcd_t              bcd_q, bcd_d;
  bcd_t              adj;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  // Correct each digit that would overflow on doubling, then shift
  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      adj[k] = (bcd_q[k] >= ADJ_LIMIT) ? bcd_q[k] + ADJ_ADD : bcd_q[k];
    end
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.step) begin
      bin_d = {bin_q[BIN_W-2:0], 1'b0};
      bcd_d = bcd_t'({adj, bin_q[BIN_W-1]});
      cnt_d = cnt_q + STEP_W'(1);
    end
  end

  // Step counter is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.last_step = (cnt_q == STEP_W'(BIN_W - 1));
  assign digits_o         = bcd_q;

endmodule

// ===== test/binary_to_decimal_ascii_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench for binary_to_decimal_ascii_unit: drives 64-bit values and checks each ASCII
// digit transfer against a local repeated-divide-by-ten prediction.
// Depends on bdau_pkg and the bdau_in_if / bdau_out_if channel interfaces.
module binary_to_decimal_ascii_unit_test import bdau_pkg::*;;

  localparam int unsigned MAX_DIGITS    = DEFAULT_MAX_DIGITS;
  localparam int unsigned DIGIT_CAP     = (MAX_DIGITS < 1) ? 1 :
                                          (MAX_DIGITS > STORE_DEPTH) ? STORE_DEPTH : MAX_DIGITS;
  localparam logic [BIN_W-1:0] DECIMAL_BASE = BIN_W'(10);
  localparam int unsigned RANDOM_VALUES = 250;
  localparam int unsigned SETTLE_CYCLES = 1 + BIN_W + STORE_DEPTH + 40;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } ascii_char_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bdau_in_if  value_ch ();
  bdau_out_if char_ch ();

  binary_to_decimal_ascii_unit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (value_ch),
    .out_o (char_ch)
  );

  logic [BIN_W-1:0] pending_values[$];
  ascii_char_t      expected_chars[$];
  int unsigned      values_total;
  int unsigned      values_taken;
  int unsigned      mismatches;
  int unsigned      value_gap;
  int unsigned      char_stall;
  logic             value_taken;
  logic             char_taken;

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the decimal characters of one value, most significant first
  task automatic predict_decimal(input logic [BIN_W-1:0] value);
    logic [BIN_W-1:0] rest;
    digit_t           digits[STORE_DEPTH];
    int unsigned      n;
    ascii_char_t      c;
    rest = value;
    n    = 0;
    while (rest != '0 && n < DIGIT_CAP) begin
      digits[n] = digit_t'(rest % DECIMAL_BASE);
      rest      = rest / DECIMAL_BASE;
      n++;
    end
    while (n > 0) begin
      n--;
      c.digit_char = ASCII_ZERO + CHAR_W'(digits[n]);
      c.last_digit = (n == 0);
      expected_chars.push_back(c);
    end
  endtask

  // Monitor: record transfers on both channels at the rising edge
  always @(posedge clk_i) begin
    ascii_char_t want;
    value_taken = 1'b0;
    char_taken  = 1'b0;
    if (rst_ni) begin
      if (value_ch.valid && value_ch.ready) begin
        value_taken = 1'b1;
        values_taken++;
        predict_decimal(value_ch.value);
      end
      if (char_ch.valid && char_ch.ready) begin
        char_taken = 1'b1;
        if (expected_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected character: digit_char=%0d last_digit=%0b",
                     char_ch.digit_char, char_ch.last_digit);
        end else begin
          want = expected_chars.pop_front();
          if (char_ch.digit_char !== want.digit_char ||
              char_ch.last_digit !== want.last_digit) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("character mismatch: expected digit_char=%0d last_digit=%0b, got %0d %0b",
                       want.digit_char, want.last_digit,
                       char_ch.digit_char, char_ch.last_digit);
          end
        end
      end
    end
  end

  // Value driver: hold until transferred, then wait a random gap before the next value
  always @(negedge clk_i) begin
    if (rst_ni && !(value_ch.valid && !value_taken)) begin
      if (value_ch.valid)
        value_gap = $urandom_range(0, 3);
      if (value_gap != 0 || pending_values.size() == 0) begin
        value_ch.valid <= 1'b0;
        if (value_gap != 0)
          value_gap--;
      end else begin
        value_ch.valid <= 1'b1;
        value_ch.value <= pending_values.pop_front();
      end
    end
  end

  // Character sink: after each transfer drop ready for a random stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (char_taken)
        char_stall = $urandom_range(0, 3);
      if (char_stall != 0) begin
        char_ch.ready <= 1'b0;
        char_stall--;
      end else begin
        char_ch.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [BIN_W-1:0] pow10;
    logic [BIN_W-1:0] rnd;
    int unsigned      width;
    int unsigned      pick;
    value_ch.valid = 1'b0;
    value_ch.value = '0;
    char_ch.ready  = 1'b0;
    rst_ni         = 1'b0;
    values_taken   = 0;
    mismatches     = 0;
    value_gap      = 0;
    char_stall     = 0;
    value_taken    = 1'b0;
    char_taken     = 1'b0;

    // Directed: zero, single digits, decade edges, twenty-digit values, bit patterns
    pending_values.push_back('0);
    pending_values.push_back(64'd1);
    pending_values.push_back(64'd9);
    pending_values.push_back(64'd10);
    pending_values.push_back('0);
    pending_values.push_back('0);
    pending_values.push_back(64'd99);
    pending_values.push_back(64'd100);
    pending_values.push_back(64'd1000000007);
    pending_values.push_back(64'd9999999999999999999);
    pending_values.push_back(64'd10000000000000000000);
    pending_values.push_back(64'd12345678901234567890);
    pending_values.push_back(64'd18446744073709551614);
    pending_values.push_back('1);
    pending_values.push_back(64'h8000_0000_0000_0000);
    pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_values.push_back(64'h5555_5555_5555_5555);
    pending_values.push_back(64'h0000_0001_0000_0000);
    pending_values.push_back(64'd4294967295);
    pending_values.push_back(64'd1010101010);
    pending_values.push_back('0);

    // Random: mostly varied widths, some zeros and decade edges
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      pick = $urandom_range(0, 19);
      rnd  = {$urandom, $urandom};
      if (pick == 0) begin
        rnd = '0;
      end else if (pick <= 2) begin
        pow10 = BIN_W'(1);
        width = $urandom_range(0, 19);
        for (int k = 0; k < width; k++)
          pow10 = pow10 * DECIMAL_BASE;
        rnd = (pick == 1) ? pow10 : pow10 - BIN_W'(1);
        if (rnd == '0)
          rnd = BIN_W'(9);
      end else if (pick <= 8) begin
        // full width values reach every bit
      end else begin
        width = $urandom_range(1, BIN_W - 1);
        rnd   = rnd & ((BIN_W'(1) << width) - BIN_W'(1));
      end
      pending_values.push_back(rnd);
    end
    values_total = pending_values.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every value, then every character, then let the unit settle
    while (values_taken < values_total)
      @(posedge clk_i);
    while (expected_chars.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("binary_to_decimal_ascii_unit_test: clean");
    end else begin
      $display("binary_to_decimal_ascii_unit_test: errors");
    end
    $finish;
  end

  // Timeout guard
  initial begin
    #5ms;
    $display("binary_to_decimal_ascii_unit_test: errors");
    $finish;
  end

endmodule
